FILE: rtl/aard_pkg.sv
// Shared widths, configuration and queue item types for the area-average downscaler.
`timescale 1ns / 1ps

package aard_pkg;

  localparam int PIX_W     = 8;   // one color or alpha channel
  localparam int DIM_W     = 13;  // image sizes, positions and axis weights
  localparam int COORD_W   = 12;  // reported destination coordinate
  localparam int CFG_IDX_W = 3;
  localparam int QW        = 9;   // quotient bits per divider lane

  // configuration register map
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
  } cfg_t;

  // One classified source pixel: position, overlap weights and emit flags.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic [DIM_W-1:0] wx0;
    logic [DIM_W-1:0] wx1;
    logic [DIM_W-1:0] wy0;
    logic [DIM_W-1:0] wy1;
    logic             emit;
    logic             last;
  } item_t;

endpackage

FILE: rtl/aard_pix_if.sv
// Source pixel channel: valid/ready handshake with RGBA payload.
`timescale 1ns / 1ps

interface aard_pix_if;
  logic                       valid;
  logic                       ready;
  logic [aard_pkg::PIX_W-1:0] in_red;
  logic [aard_pkg::PIX_W-1:0] in_green;
  logic [aard_pkg::PIX_W-1:0] in_blue;
  logic [aard_pkg::PIX_W-1:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, output ready);
endinterface

FILE: rtl/aard_res_if.sv
// Destination pixel channel: valid/ready handshake with RGBA, position and frame end.
`timescale 1ns / 1ps

interface aard_res_if;
  logic                         valid;
  logic                         ready;
  logic [aard_pkg::PIX_W-1:0]   out_red;
  logic [aard_pkg::PIX_W-1:0]   out_green;
  logic [aard_pkg::PIX_W-1:0]   out_blue;
  logic [aard_pkg::PIX_W-1:0]   out_alpha;
  logic [aard_pkg::COORD_W-1:0] out_x;
  logic [aard_pkg::COORD_W-1:0] out_y;
  logic                         frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output out_x, output out_y, output frame_end,
                  input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_alpha, input out_x, input out_y, input frame_end,
                output ready);
endinterface

FILE: rtl/aard_queue.sv
// Two-entry request queue between the classifier and the accumulator.
`timescale 1ns / 1ps

module aard_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aard_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output aard_pkg::item_t head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  aard_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [PW:0]     cnt_r;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_item;
  end

endmodule

FILE: rtl/aard_front.sv
// Front end: accepts source pixels and works out destination cells and overlap weights.
`timescale 1ns / 1ps

module aard_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            restart,
  input  aard_pkg::cfg_t  cfg,
  input  logic            cfg_ok,
  input  logic            clearing,
  aard_pix_if.sink        in_pix,
  output logic            push,
  output aard_pkg::item_t push_item,
  input  logic            q_full
);

  localparam int DW = aard_pkg::DIM_W;

  typedef struct packed {
    logic [DW-1:0] w0;
    logic [DW-1:0] w1;
    logic          done;
    logic [DW-1:0] rem_nxt;
  } axis_t;

  // rem is the distance from the current source edge to the next destination edge
  function automatic axis_t split(input logic [DW-1:0] rem, input logic [DW-1:0] dn,
                                  input logic [DW-1:0] sn);
    axis_t a;
    a.w0      = dn;
    a.w1      = '0;
    a.done    = 1'b0;
    a.rem_nxt = rem - dn;
    if (rem < dn) begin
      a.w0      = rem;
      a.w1      = dn - rem;
      a.done    = 1'b1;
      a.rem_nxt = sn - (dn - rem);
    end else if (rem == dn) begin
      a.done    = 1'b1;
      a.rem_nxt = sn;
    end
    return a;
  endfunction

  logic [DW-1:0] col_r, row_r, cx_r, cy_r, rem_x_r, rem_y_r;
  logic [DW-1:0] rem_x, rem_y;
  axis_t         ax, ay;
  logic          acc, row_end, frame_wrap;

  assign rem_x = (col_r == '0) ? cfg.src_width  : rem_x_r;
  assign rem_y = (row_r == '0) ? cfg.src_height : rem_y_r;
  assign ax    = split(rem_x, cfg.dst_width,  cfg.src_width);
  assign ay    = split(rem_y, cfg.dst_height, cfg.src_height);

  assign row_end    = (col_r == cfg.src_width  - 1'b1);
  assign frame_wrap = (row_r == cfg.src_height - 1'b1);

  assign in_pix.ready = !q_full && !clearing;
  assign acc          = in_pix.valid && in_pix.ready;
  assign push         = acc && cfg_ok;

  always_comb begin
    push_item.red   = in_pix.in_red;
    push_item.green = in_pix.in_green;
    push_item.blue  = in_pix.in_blue;
    push_item.alpha = in_pix.in_alpha;
    push_item.cx    = cx_r;
    push_item.cy    = cy_r;
    push_item.wx0   = ax.w0;
    push_item.wx1   = ax.w1;
    push_item.wy0   = ay.w0;
    push_item.wy1   = ay.w1;
    push_item.emit  = ax.done && ay.done;
    push_item.last  = (cx_r == cfg.dst_width - 1'b1) && (cy_r == cfg.dst_height - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      row_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (push) begin
      if (row_end) begin
        col_r <= '0;
        cx_r  <= '0;
        if (frame_wrap) begin
          row_r <= '0;
          cy_r  <= '0;
        end else begin
          row_r   <= row_r + 1'b1;
          cy_r    <= ay.done ? cy_r + 1'b1 : cy_r;
          rem_y_r <= ay.rem_nxt;
        end
      end else begin
        col_r   <= col_r + 1'b1;
        cx_r    <= ax.done ? cx_r + 1'b1 : cx_r;
        rem_x_r <= ax.rem_nxt;
      end
    end
  end

endmodule

FILE: rtl/aard_back.sv
// Back end: line-store accumulation, rounding dividers and the output register.
`timescale 1ns / 1ps

module aard_back #(
  parameter int MAX_DIM = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            restart,
  output logic            clearing,
  input  logic            q_valid,
  input  aard_pkg::item_t q_head,
  output logic            q_pop,
  aard_res_if.source      out_res
);

  localparam int DW    = aard_pkg::DIM_W;
  localparam int PW    = aard_pkg::PIX_W;
  localparam int QW    = aard_pkg::QW;
  localparam int CAW   = $clog2(MAX_DIM);
  localparam int MAW   = CAW + 1;
  localparam int DEPTH = 2 ** MAW;
  localparam longint unsigned MAX_AREA = longint'(MAX_DIM) * longint'(MAX_DIM);
  localparam int AW    = $clog2(MAX_AREA + 1);
  localparam int ALW   = $clog2(MAX_AREA * 255 + 1);
  localparam int CLW   = $clog2(MAX_AREA * 255 * 255 + 1);
  localparam int LW    = CLW + QW;
  localparam int NL    = 4;
  localparam int SW    = $clog2(QW);

  typedef struct packed {
    logic [CLW-1:0] r;
    logic [CLW-1:0] g;
    logic [CLW-1:0] b;
    logic [ALW-1:0] a;
    logic [AW-1:0]  area;
  } sum_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_WMUL  = 9'b000000100,
    S_AMUL  = 9'b000001000,
    S_CMUL  = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_DINIT = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  function automatic logic [PW-1:0] clamp(input logic [QW-1:0] q);
    return (q > QW'({PW{1'b1}})) ? {PW{1'b1}} : q[PW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  aard_pkg::item_t item_r;
  logic [1:0]      k_r, k_nxt;
  logic            has_next;
  logic [3:0]      tmask;
  logic [MAW-1:0]  clr_r, addr;
  logic [SW-1:0]   dstep_r;

  logic [DW-1:0]   wx_sel, wy_sel, col, row;
  logic [2*DW-1:0] w_full;
  logic [AW-1:0]   w_r;
  logic [ALW-1:0]  wa_r, wa_full;
  logic [CLW-1:0]  cr_r, cg_r, cb_r, cr_full, cg_full, cb_full;

  sum_t            store_mem [DEPTH];
  sum_t            rd_r, nsum, emit_sum_r, mem_wdata;
  logic            mem_we;
  logic [MAW-1:0]  mem_waddr;

  logic [LW-1:0]   num [NL];
  logic [LW-1:0]   den [NL];
  logic [LW-1:0]   rem_r [NL];
  logic [LW-1:0]   ds_r [NL];
  logic [QW-1:0]   q_r [NL];
  logic            zero;

  logic            out_v_r, out_load, last_r;
  logic [PW-1:0]   o_red_r, o_green_r, o_blue_r, o_alpha_r;
  logic [aard_pkg::COORD_W-1:0] o_x_r, o_y_r;

  // target k: bit 0 picks the right column, bit 1 the lower row
  assign wx_sel = k_r[0] ? item_r.wx1 : item_r.wx0;
  assign wy_sel = k_r[1] ? item_r.wy1 : item_r.wy0;
  assign col    = item_r.cx + DW'(k_r[0]);
  assign row    = item_r.cy + DW'(k_r[1]);
  assign addr   = {row[0], CAW'(col)};
  assign w_full = wx_sel * wy_sel;
  assign wa_full = w_r * item_r.alpha;
  assign cr_full = wa_r * item_r.red;
  assign cg_full = wa_r * item_r.green;
  assign cb_full = wa_r * item_r.blue;

  assign tmask = {(item_r.wx1 != '0) && (item_r.wy1 != '0), item_r.wy1 != '0,
                  item_r.wx1 != '0, 1'b1};

  always_comb begin
    has_next = 1'b0;
    k_nxt    = k_r;
    for (int j = NL - 1; j >= 1; j--) begin
      if (j > k_r && tmask[j]) begin
        has_next = 1'b1;
        k_nxt    = 2'(j);
      end
    end
  end

  always_comb begin
    nsum.area = rd_r.area + w_r;
    nsum.a    = rd_r.a + wa_r;
    nsum.r    = rd_r.r + cr_r;
    nsum.g    = rd_r.g + cg_r;
    nsum.b    = rd_r.b + cb_r;
  end

  // the emitted cell is written back as zero so the next frame starts clean
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || (state_r == S_ACC);
    mem_waddr = (state_r == S_CLEAR) ? clr_r : addr;
    mem_wdata = nsum;
    if (state_r == S_CLEAR || (k_r == '0 && item_r.emit)) mem_wdata = '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    if (state_r == S_AMUL) rd_r <= store_mem[addr];
  end

  assign clearing = (state_r == S_CLEAR);
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_OUT) && (!out_v_r || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == {MAW{1'b1}}) state_nxt = S_IDLE;
      S_IDLE:  if (q_valid) state_nxt = S_WMUL;
      S_WMUL:  state_nxt = S_AMUL;
      S_AMUL:  state_nxt = S_CMUL;
      S_CMUL:  state_nxt = S_ACC;
      S_ACC: begin
        if (has_next)         state_nxt = S_WMUL;
        else if (item_r.emit) state_nxt = S_DINIT;
        else                  state_nxt = S_IDLE;
      end
      S_DINIT: state_nxt = S_DIV;
      S_DIV:   if (dstep_r == SW'(QW - 1)) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
    if (restart) state_nxt = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      k_r     <= '0;
      dstep_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (restart)                 clr_r <= '0;
      else if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (q_pop)                            k_r <= '0;
      else if (state_r == S_ACC && has_next) k_r <= k_nxt;
      if (state_r == S_DIV) dstep_r <= dstep_r + 1'b1;
      else                  dstep_r <= '0;
      if (out_load)           out_v_r <= 1'b1;
      else if (out_res.ready) out_v_r <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < NL - 1; i++) den[i] = LW'(emit_sum_r.a);
    num[0] = LW'(emit_sum_r.r);
    num[1] = LW'(emit_sum_r.g);
    num[2] = LW'(emit_sum_r.b);
    num[3] = LW'(emit_sum_r.a);
    den[3] = LW'(emit_sum_r.area);
  end

  assign zero = (emit_sum_r.a == '0) || (emit_sum_r.area == '0);

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_head;
    if (state_r == S_WMUL) w_r <= AW'(w_full);
    if (state_r == S_AMUL) wa_r <= wa_full;
    if (state_r == S_CMUL) begin
      cr_r <= cr_full;
      cg_r <= cg_full;
      cb_r <= cb_full;
    end
    if (state_r == S_ACC && k_r == '0) emit_sum_r <= nsum;
    // restoring division of (2n + d) by 2d, one quotient bit per cycle
    for (int i = 0; i < NL; i++) begin
      if (state_r == S_DINIT) begin
        rem_r[i] <= (num[i] << 1) + den[i];
        ds_r[i]  <= den[i] << QW;
        q_r[i]   <= '0;
      end else if (state_r == S_DIV) begin
        if (rem_r[i] >= ds_r[i]) begin
          rem_r[i] <= rem_r[i] - ds_r[i];
          q_r[i]   <= {q_r[i][QW-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][QW-2:0], 1'b0};
        end
        ds_r[i] <= ds_r[i] >> 1;
      end
    end
    if (out_load) begin
      o_red_r   <= zero ? '0 : clamp(q_r[0]);
      o_green_r <= zero ? '0 : clamp(q_r[1]);
      o_blue_r  <= zero ? '0 : clamp(q_r[2]);
      o_alpha_r <= zero ? '0 : clamp(q_r[3]);
      o_x_r     <= aard_pkg::COORD_W'(item_r.cx);
      o_y_r     <= aard_pkg::COORD_W'(item_r.cy);
      last_r    <= item_r.last;
    end
  end

  assign out_res.valid     = out_v_r;
  assign out_res.out_red   = o_red_r;
  assign out_res.out_green = o_green_r;
  assign out_res.out_blue  = o_blue_r;
  assign out_res.out_alpha = o_alpha_r;
  assign out_res.out_x     = o_x_r;
  assign out_res.out_y     = o_y_r;
  assign out_res.frame_end = last_r;

endmodule

FILE: rtl/area_average_rgba_downscaler.sv
// Area-average RGBA downscaler top: config registers, front end, request queue, back end.
// Each request runs the multiply and accumulate states once per touched line-store cell
//   (1, 2 or 4 cells), then setup, 9 divide steps and output load when it closes a cell.
// The back end serves one request at a time; up to two more wait in the request queue.
// A result comes later while earlier requests wait or the result register is held.
// Rate is set by the single read/write line-store port and the bit-serial dividers.
// Reset (sync, active low) and each write to a known register run a clearing pass over all
//   2*2^ceil(log2(MAX_DIM)) store cells (8192 by default); no pixel is taken meanwhile.
`timescale 1ns / 1ps

module area_average_rgba_downscaler #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [aard_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aard_pkg::DIM_W-1:0]     cfg_wdata,
  aard_pix_if.sink                       in_pix,
  aard_res_if.source                     out_res
);

  localparam int DW = aard_pkg::DIM_W;

  logic [DW-1:0]   src_width_r, src_height_r, dst_width_r, dst_height_r;
  aard_pkg::cfg_t  cfg;
  logic            cfg_ok, restart, clearing;
  logic            q_push, q_full, q_pop, q_valid;
  aard_pkg::item_t push_item, q_head;

  // any write to a known register restarts the frame and clears the line stores
  assign restart = cfg_we && (cfg_index < aard_pkg::CFG_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DW'(1);
      src_height_r <= DW'(1);
      dst_width_r  <= DW'(1);
      dst_height_r <= DW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        aard_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        aard_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        aard_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata;
        aard_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = '{src_width: src_width_r, src_height: src_height_r,
                 dst_width: dst_width_r, dst_height: dst_height_r};

  // upscaling or out-of-range sizes: pixels are taken and dropped
  assign cfg_ok = (src_width_r  != '0) && (32'(src_width_r)  <= MAX_DIM) &&
                  (src_height_r != '0) && (32'(src_height_r) <= MAX_DIM) &&
                  (dst_width_r  != '0) && (dst_height_r != '0) &&
                  (dst_width_r  <= src_width_r) && (dst_height_r <= src_height_r);

  aard_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .cfg       (cfg),
    .cfg_ok    (cfg_ok),
    .clearing  (clearing),
    .in_pix    (in_pix),
    .push      (q_push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  aard_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  aard_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_res  (out_res)
  );

  // a register write must hold off pixels while the stores clear
  a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> !in_pix.ready)
    else $error("pixel input open right after a register write");

  // the front end never pushes into a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result valid after reset");

endmodule

FILE: tb/aard_tb_pix_if.sv
// Testbench types: source pixel and expected destination pixel records.
`timescale 1ns / 1ps

package aard_tb_pkg;

  typedef struct packed {
    logic [aard_pkg::PIX_W-1:0] red;
    logic [aard_pkg::PIX_W-1:0] green;
    logic [aard_pkg::PIX_W-1:0] blue;
    logic [aard_pkg::PIX_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [aard_pkg::PIX_W-1:0]   red;
    logic [aard_pkg::PIX_W-1:0]   green;
    logic [aard_pkg::PIX_W-1:0]   blue;
    logic [aard_pkg::PIX_W-1:0]   alpha;
    logic [aard_pkg::COORD_W-1:0] x;
    logic [aard_pkg::COORD_W-1:0] y;
    logic                         frame_end;
  } dst_pix_t;

endpackage

FILE: tb/tb_area_average_rgba_downscaler.sv
// Self-checking testbench for the area-average RGBA downscaler.
`timescale 1ns / 1ps

module tb_area_average_rgba_downscaler;

  localparam int MAXD     = 4096;
  localparam int DEPTH    = 2 * MAXD;
  localparam int SETTLE   = 60;   // drains requests that close no cell
  localparam int HOLD_LEN = 400;  // long receiver stall, in cycles
  // an index past the register map
  localparam logic [aard_pkg::CFG_IDX_W-1:0] CFG_UNUSED = aard_pkg::CFG_COUNT + 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [aard_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [aard_pkg::DIM_W-1:0] cfg_wdata = '0;

  aard_pix_if pix ();
  aard_res_if res ();

  area_average_rgba_downscaler i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_pix(pix), .out_res(res)
  );

  always #5 clk = ~clk;

  // ---------------- shadow of the block ----------------
  // Configuration, mirrored at register write, and frame position, updated at request acceptance.
  int unsigned sw = 1, sh = 1, dw = 1, dh = 1;
  int unsigned col_pos, row_pos;
  // Two line stores, indexed by destination-row parity and column.
  longint unsigned area_acc [DEPTH];
  longint unsigned alpha_acc[DEPTH];
  longint unsigned red_acc  [DEPTH];
  longint unsigned green_acc[DEPTH];
  longint unsigned blue_acc [DEPTH];

  aard_tb_pkg::dst_pix_t pending_dst[$];   // destination pixels still owed by the block
  aard_tb_pkg::rgba_t    src_queue[$];     // source pixels not yet offered

  int   fail_cnt = 0;
  int   req_cnt = 0, dst_cnt = 0, phase_cnt = 0;
  bit   quiet = 1'b0;         // no idling on either side
  bit   hold_out = 1'b0;      // long receiver stall request

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < DEPTH; i++) begin
      area_acc[i] = 0; alpha_acc[i] = 0;
      red_acc[i] = 0; green_acc[i] = 0; blue_acc[i] = 0;
    end
  endfunction

  // Overlap of source index s with the destination grid on one axis.
  function automatic void axis_overlap(input longint unsigned s, sn, dn,
      output longint unsigned first, w0, w1, output bit closes);
    longint unsigned lo, hi, edge_pos;
    lo = s * dn;
    hi = lo + dn;
    first = lo / sn;
    edge_pos = (first + 1) * sn;
    if (edge_pos < hi) begin
      w0 = edge_pos - lo; w1 = hi - edge_pos; closes = 1'b1;
    end else begin
      w0 = dn; w1 = 0; closes = (edge_pos == hi);
    end
  endfunction

  function automatic void accumulate(longint unsigned c, r, w, aard_tb_pkg::rgba_t p);
    int idx;
    longint unsigned wa;
    if (w == 0 || c >= MAXD) return;
    idx = int'((r & 1) * MAXD + c);
    wa = w * p.alpha;
    area_acc[idx]  += w;
    alpha_acc[idx] += wa;
    red_acc[idx]   += wa * p.red;
    green_acc[idx] += wa * p.green;
    blue_acc[idx]  += wa * p.blue;
  endfunction

  function automatic logic [7:0] round_div(longint unsigned num, den);
    longint unsigned v;
    v = (2 * num + den) / (2 * den);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Fold one accepted source pixel into the stores; queue a result if it closes one.
  function automatic void fold_pixel(aard_tb_pkg::rgba_t p);
    longint unsigned cx, wx0, wx1, cy, wy0, wy1, asum, area;
    bit cdone, rdone;
    int idx;
    aard_tb_pkg::dst_pix_t d;
    if (sw < 1 || sw > MAXD || sh < 1 || sh > MAXD || dw < 1 || dh < 1 ||
        dw > sw || dh > sh) return;  // invalid setup: pixel dropped
    if (col_pos >= sw || row_pos >= sh) begin
      col_pos = 0; row_pos = 0;
    end
    axis_overlap(col_pos, sw, dw, cx, wx0, wx1, cdone);
    axis_overlap(row_pos, sh, dh, cy, wy0, wy1, rdone);
    accumulate(cx,     cy,     wx0 * wy0, p);
    accumulate(cx + 1, cy,     wx1 * wy0, p);
    accumulate(cx,     cy + 1, wx0 * wy1, p);
    accumulate(cx + 1, cy + 1, wx1 * wy1, p);
    col_pos++;
    if (col_pos >= sw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= sh) row_pos = 0;
    end
    if (!(cdone && rdone) || cx >= MAXD) return;
    idx = int'((cy & 1) * MAXD + cx);
    asum = alpha_acc[idx];
    area = area_acc[idx];
    if (asum == 0 || area == 0) begin
      d.red = 0; d.green = 0; d.blue = 0; d.alpha = 0;  // fully transparent
    end else begin
      d.red   = round_div(red_acc[idx], asum);
      d.green = round_div(green_acc[idx], asum);
      d.blue  = round_div(blue_acc[idx], asum);
      d.alpha = round_div(asum, area);
    end
    d.x = cx[aard_pkg::COORD_W-1:0];
    d.y = cy[aard_pkg::COORD_W-1:0];
    d.frame_end = (cx == dw - 1 && cy == dh - 1);
    area_acc[idx] = 0; alpha_acc[idx] = 0;
    red_acc[idx] = 0; green_acc[idx] = 0; blue_acc[idx] = 0;
    pending_dst.push_back(d);
  endfunction

  // ---------------- source driver ----------------
  int src_idle = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
      pix.in_red <= '0; pix.in_green <= '0; pix.in_blue <= '0; pix.in_alpha <= '0;
    end else begin
      if (pix.valid && pix.ready) begin
        fold_pixel({pix.in_red, pix.in_green, pix.in_blue, pix.in_alpha});
        req_cnt++;
      end
      if (!pix.valid || pix.ready) begin
        if (src_idle > 0) begin
          src_idle--;
          pix.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_idle = $urandom_range(1, 12);
          pix.valid <= 1'b0;
        end else if (src_queue.size() > 0) begin
          aard_tb_pkg::rgba_t p;
          p = src_queue.pop_front();
          pix.valid <= 1'b1;
          pix.in_red <= p.red; pix.in_green <= p.green;
          pix.in_blue <= p.blue; pix.in_alpha <= p.alpha;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- long receiver stall ----------------
  // starts on the first result while hold_out is set, then runs until hold_cnt reaches HOLD_LEN
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_cnt == 0) begin
      if (hold_out && res.valid) hold_cnt <= 1;
    end else if (hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // ---------------- result monitor ----------------
  int sink_idle = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        dst_cnt++;
        if (pending_dst.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", res.out_x, res.out_y);
          fail_cnt++;
        end else begin
          aard_tb_pkg::dst_pix_t e;
          e = pending_dst.pop_front();
          if (res.out_red !== e.red) begin
            $error("out_red exp %0d got %0d", e.red, res.out_red); fail_cnt++;
          end
          if (res.out_green !== e.green) begin
            $error("out_green exp %0d got %0d", e.green, res.out_green); fail_cnt++;
          end
          if (res.out_blue !== e.blue) begin
            $error("out_blue exp %0d got %0d", e.blue, res.out_blue); fail_cnt++;
          end
          if (res.out_alpha !== e.alpha) begin
            $error("out_alpha exp %0d got %0d", e.alpha, res.out_alpha); fail_cnt++;
          end
          if (res.out_x !== e.x) begin
            $error("out_x exp %0d got %0d", e.x, res.out_x); fail_cnt++;
          end
          if (res.out_y !== e.y) begin
            $error("out_y exp %0d got %0d", e.y, res.out_y); fail_cnt++;
          end
          if (res.frame_end !== e.frame_end) begin
            $error("frame_end exp %0d got %0d", e.frame_end, res.frame_end); fail_cnt++;
          end
        end
      end
      // long back-pressure window so the request queue fills up
      if (hold_cnt > 0 && hold_cnt < HOLD_LEN) begin
        res.ready <= 1'b0;
      end else if (sink_idle > 0) begin
        sink_idle--;
        res.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_idle = $urandom_range(1, 12);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic wait_idle();
    while (src_queue.size() != 0 || pix.valid || pending_dst.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [aard_pkg::CFG_IDX_W-1:0] r, int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v[aard_pkg::DIM_W-1:0];
    case (r)
      aard_pkg::CFG_SRC_WIDTH:  sw = v;
      aard_pkg::CFG_SRC_HEIGHT: sh = v;
      aard_pkg::CFG_DST_WIDTH:  dw = v;
      aard_pkg::CFG_DST_HEIGHT: dh = v;
      default: ;
    endcase
    if (r < aard_pkg::CFG_COUNT) restart_frame();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int unsigned a, b, c, d);
    wait_idle();
    write_reg(aard_pkg::CFG_SRC_WIDTH, a);
    write_reg(aard_pkg::CFG_SRC_HEIGHT, b);
    write_reg(aard_pkg::CFG_DST_WIDTH, c);
    write_reg(aard_pkg::CFG_DST_HEIGHT, d);
    phase_cnt++;
  endtask

  function automatic aard_tb_pkg::rgba_t rand_pixel();
    aard_tb_pkg::rgba_t p;
    p = $urandom;
    case ($urandom_range(0, 9))
      0: p.alpha = 8'd0;
      1: p.alpha = 8'd255;
      2: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) src_queue.push_back(rand_pixel());
  endtask

  initial begin
    int unsigned a, b, c, d;
    restart_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 1x1 frames at reset sizes, field extremes and zero alpha.
    src_queue.push_back('0);
    src_queue.push_back('1);
    src_queue.push_back(32'h00FF_FF00);
    src_queue.push_back(32'hFF00_00FF);
    src_queue.push_back(32'hAA55_AA01);
    src_queue.push_back(32'h55AA_5580);
    // 3x3 -> 2x2: uneven split in both axes, one fully transparent frame
    setup(3, 3, 2, 2);
    for (int i = 0; i < 9; i++) src_queue.push_back(32'h1234_5600);
    for (int i = 0; i < 9; i++) src_queue.push_back(rand_pixel());
    // unused register index: no effect at a frame boundary
    wait_idle();
    write_reg(CFG_UNUSED, 0);
    push_random(9);
    // invalid setups: pixels are dropped
    setup(2, 2, 3, 1);
    push_random(3);
    setup(0, 2, 1, 1);
    push_random(3);
    setup(8191, 2, 1, 1);
    push_random(3);
    // largest sizes, partial frames only
    setup(4096, 4096, 4096, 4096);
    push_random(40);
    setup(4096, 4096, 1, 1);
    push_random(40);
    setup(4096, 2, 4095, 1);
    push_random(40);
    setup(1, 4096, 1, 4095);
    push_random(40);
    // receiver stalls while two frames are offered, so the block backs up
    setup(6, 6, 4, 3);
    hold_out = 1'b1;
    push_random(72);

    // Random: small frames, mostly whole frames.
    while (req_cnt + src_queue.size() < 1300) begin
      a = $urandom_range(1, 12);
      b = $urandom_range(1, 12);
      c = $urandom_range(1, a);
      d = $urandom_range(1, b);
      setup(a, b, c, d);
      push_random(a * b * $urandom_range(1, 3) + (($urandom_range(0, 4) == 0) ? 3 : 0));
    end
    // closing stretch without idling
    setup(7, 5, 3, 2);
    quiet = 1'b1;
    push_random(70);
    wait_idle();

    $display("Covered %0d phases, %0d source requests, %0d destination pixels checked.",
             phase_cnt, req_cnt, dst_cnt);
    if (fail_cnt == 0) begin
      $display("area_average_rgba_downscaler test passed");
    end else begin
      $display("area_average_rgba_downscaler test failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("area_average_rgba_downscaler test failed");
    $finish;
  end
endmodule
